// File: rtl/shape_pair_overlap_tester_defines.svh
// Assertion macros shared by the shape pair overlap tester RTL.
`ifndef SHAPE_PAIR_OVERLAP_TESTER_DEFINES_SVH
`define SHAPE_PAIR_OVERLAP_TESTER_DEFINES_SVH

`ifndef SYNTH
// clocked check, masked while reset is high
`define SPOT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("spot assertion failed");
// clocked check that also runs through reset
`define SPOT_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("spot assertion failed");
`else
`define SPOT_ASSERT(lbl, clk, rst, prop)
`define SPOT_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// File: rtl/spot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spot_pkg;

   // coordinate width (signed centers); sizes are one bit narrower
   localparam int CW = 24;
   localparam int SW = CW - 1;
   // signed center difference
   localparam int DW = CW + 1;
   // magnitude of a center difference
   localparam int MW = CW + 1;
   // multiplier operand width (doubled corner offsets)
   localparam int OW = CW + 2;
   // square and sum-of-squares widths
   localparam int QW = 2 * OW;
   localparam int SQW = QW + 1;

   // stream word widths
   localparam int REQ_BITS = 4 * CW + 4 * SW;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 8;

   // pair kind
   typedef enum logic [1:0] {
      OP_RR   = 2'd0,
      OP_RC   = 2'd1,
      OP_CC   = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   // one input word, unpacked
   typedef struct packed {
      op_type                 op;
      logic signed [CW-1:0]   a_x;
      logic signed [CW-1:0]   a_y;
      logic [SW-1:0]          a_w;
      logic [SW-1:0]          a_h;
      logic signed [CW-1:0]   b_x;
      logic signed [CW-1:0]   b_y;
      logic [SW-1:0]          b_w;
      logic [SW-1:0]          b_h;
   } pair_type;

   // geometry front end to distance back end
   typedef struct packed {
      op_type        op;
      logic [MW-1:0] mag_x;    // |ax - bx|
      logic [MW-1:0] mag_y;    // |ay - by|
      logic [CW-1:0] lim;      // radius sum or larger side plus radius
      logic [OW-1:0] cmag_x;   // doubled offset to nearest corner
      logic [OW-1:0] cmag_y;
      logic [CW-1:0] r2;       // doubled radius
      logic          rr;       // rect-rect overlap
      logic          ctr;      // circle center inside rect
      logic          side;     // side-edge test passed
   } geom_type;

endpackage

`default_nettype wire

// File: rtl/spot_geom.sv
`timescale 1ns / 1ps
`default_nettype none
`include "shape_pair_overlap_tester_defines.svh"

module spot_geom (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  spot_pkg::pair_type  in_pair,
   output logic                out_valid,
   input  logic                out_ready,
   output spot_pkg::geom_type  out_geom
);

   localparam int CW = spot_pkg::CW;
   localparam int SW = spot_pkg::SW;
   localparam int DW = spot_pkg::DW;
   localparam int MW = spot_pkg::MW;
   localparam int OW = spot_pkg::OW;

   // stage valids and readies
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic rdy1, rdy2, rdy3;

   assign rdy3 = !s3_valid_ff || out_ready;
   assign rdy2 = !s2_valid_ff || rdy3;
   assign rdy1 = !s1_valid_ff || rdy2;
   assign in_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff <= in_valid;
         if (rdy2) s2_valid_ff <= s1_valid_ff;
         if (rdy3) s3_valid_ff <= s2_valid_ff;
      end
   end

   // ---------------- stage 1: center differences and size sums
   spot_pkg::op_type      s1_op_ff;
   logic signed [DW-1:0]  s1_dx_ff, s1_dx_in;
   logic signed [DW-1:0]  s1_dy_ff, s1_dy_in;
   logic [CW-1:0]         s1_sum_w_ff, s1_sum_w_in;
   logic [CW-1:0]         s1_sum_h_ff, s1_sum_h_in;
   logic [CW-1:0]         s1_lim_rc_ff, s1_lim_rc_in;
   logic [SW-1:0]         s1_w_ff, s1_h_ff, s1_r_ff;

   always_comb begin
      logic [SW-1:0] big;
      big = (in_pair.a_w < in_pair.a_h) ? in_pair.a_h : in_pair.a_w;
      s1_dx_in     = DW'(in_pair.a_x) - DW'(in_pair.b_x);
      s1_dy_in     = DW'(in_pair.a_y) - DW'(in_pair.b_y);
      s1_sum_w_in  = CW'(in_pair.a_w) + CW'(in_pair.b_w);
      s1_sum_h_in  = CW'(in_pair.a_h) + CW'(in_pair.b_h);
      s1_lim_rc_in = CW'(big) + CW'(in_pair.b_w);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_op_ff     <= in_pair.op;
         s1_dx_ff     <= s1_dx_in;
         s1_dy_ff     <= s1_dy_in;
         s1_sum_w_ff  <= s1_sum_w_in;
         s1_sum_h_ff  <= s1_sum_h_in;
         s1_lim_rc_ff <= s1_lim_rc_in;
         s1_w_ff      <= in_pair.a_w;
         s1_h_ff      <= in_pair.a_h;
         s1_r_ff      <= in_pair.b_w;
      end
   end

   // ---------------- stage 2: magnitudes, corner and edge offsets
   spot_pkg::op_type      s2_op_ff;
   logic [MW-1:0]         s2_mag_x_ff, s2_mag_x_in;
   logic [MW-1:0]         s2_mag_y_ff, s2_mag_y_in;
   logic signed [OW-1:0]  s2_ex_ff, s2_ex_in;
   logic signed [OW-1:0]  s2_ey_ff, s2_ey_in;
   logic signed [OW:0]    s2_cx_ff, s2_cx_in;
   logic signed [OW:0]    s2_cy_ff, s2_cy_in;
   logic [CW-1:0]         s2_lim_ff, s2_lim_in;
   logic [CW-1:0]         s2_r2_ff;
   logic [CW-1:0]         s2_sum_w_ff, s2_sum_h_ff;
   logic [SW-1:0]         s2_w_ff, s2_h_ff;

   always_comb begin
      logic                 pos_x, pos_y;
      logic signed [OW-1:0] r_e, dx_e, dy_e;
      logic signed [OW:0]   dx_c, dy_c, w_c, h_c;
      // circle center lies left of / below the rect center
      pos_x = s1_dx_ff > 0;
      pos_y = s1_dy_ff > 0;
      r_e   = OW'($signed({1'b0, s1_r_ff}));
      dx_e  = OW'(s1_dx_ff);
      dy_e  = OW'(s1_dy_ff);
      dx_c  = (OW+1)'(s1_dx_ff);
      dy_c  = (OW+1)'(s1_dy_ff);
      w_c   = (OW+1)'($signed({1'b0, s1_w_ff}));
      h_c   = (OW+1)'($signed({1'b0, s1_h_ff}));

      s2_mag_x_in = s1_dx_ff[DW-1] ? MW'(-s1_dx_ff) : MW'(s1_dx_ff);
      s2_mag_y_in = s1_dy_ff[DW-1] ? MW'(-s1_dy_ff) : MW'(s1_dy_ff);
      // nearest edge point of the circle, relative to the rect center
      s2_ex_in = pos_x ? (r_e - dx_e) : (-dx_e - r_e);
      s2_ey_in = pos_y ? (r_e - dy_e) : (-dy_e - r_e);
      // nearest corner minus circle center, doubled
      s2_cx_in = pos_x ? ((dx_c <<< 1) - w_c) : ((dx_c <<< 1) + w_c);
      s2_cy_in = pos_y ? ((dy_c <<< 1) - h_c) : ((dy_c <<< 1) + h_c);
      s2_lim_in = (s1_op_ff == spot_pkg::OP_CC) ? s1_sum_w_ff : s1_lim_rc_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_op_ff    <= s1_op_ff;
         s2_mag_x_ff <= s2_mag_x_in;
         s2_mag_y_ff <= s2_mag_y_in;
         s2_ex_ff    <= s2_ex_in;
         s2_ey_ff    <= s2_ey_in;
         s2_cx_ff    <= s2_cx_in;
         s2_cy_ff    <= s2_cy_in;
         s2_lim_ff   <= s2_lim_in;
         s2_r2_ff    <= {s1_r_ff, 1'b0};
         s2_sum_w_ff <= s1_sum_w_ff;
         s2_sum_h_ff <= s1_sum_h_ff;
         s2_w_ff     <= s1_w_ff;
         s2_h_ff     <= s1_h_ff;
      end
   end

   // ---------------- stage 3: box compares and corner magnitudes
   spot_pkg::geom_type s3_ff, s3_in;

   always_comb begin
      logic [MW-1:0] em_x, em_y;
      logic [MW:0]   dbl_x, dbl_y;
      logic          in_x, in_y, ex_ok, ey_ok;
      em_x  = s2_ex_ff[OW-1] ? MW'(-s2_ex_ff) : MW'(s2_ex_ff);
      em_y  = s2_ey_ff[OW-1] ? MW'(-s2_ey_ff) : MW'(s2_ey_ff);
      dbl_x = {s2_mag_x_ff, 1'b0};
      dbl_y = {s2_mag_y_ff, 1'b0};
      in_x  = dbl_x < (MW+1)'(s2_w_ff);
      in_y  = dbl_y < (MW+1)'(s2_h_ff);
      ex_ok = {em_x, 1'b0} < (MW+1)'(s2_w_ff);
      ey_ok = {em_y, 1'b0} < (MW+1)'(s2_h_ff);

      s3_in.op     = s2_op_ff;
      s3_in.mag_x  = s2_mag_x_ff;
      s3_in.mag_y  = s2_mag_y_ff;
      s3_in.lim    = s2_lim_ff;
      s3_in.cmag_x = s2_cx_ff[OW] ? OW'(-s2_cx_ff) : OW'(s2_cx_ff);
      s3_in.cmag_y = s2_cy_ff[OW] ? OW'(-s2_cy_ff) : OW'(s2_cy_ff);
      s3_in.r2     = s2_r2_ff;
      s3_in.rr     = (dbl_x < (MW+1)'(s2_sum_w_ff)) && (dbl_y < (MW+1)'(s2_sum_h_ff));
      s3_in.ctr    = in_x && in_y;
      s3_in.side   = (in_y && ex_ok) || (in_x && ey_ok);
   end

   always_ff @(posedge clock) begin
      if (rdy3) s3_ff <= s3_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_geom  = s3_ff;

   // an accepted word always lands in stage 1
   `SPOT_ASSERT(a_geom_accept_lands, clock, reset, in_valid && in_ready |=> s1_valid_ff)
   // a blocked stage 3 keeps the word behind it
   `SPOT_ASSERT(a_geom_stall_keeps, clock, reset, s2_valid_ff && s3_valid_ff && !out_ready |=> s2_valid_ff)

endmodule

`default_nettype wire

// File: rtl/spot_dist.sv
`timescale 1ns / 1ps
`default_nettype none
`include "shape_pair_overlap_tester_defines.svh"

module spot_dist (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  spot_pkg::geom_type  in_geom,
   output logic                out_valid,
   input  logic                out_ready,
   output logic                out_hit
);

   localparam int OW  = spot_pkg::OW;
   localparam int QW  = spot_pkg::QW;
   localparam int SQW = spot_pkg::SQW;

   logic s4_valid_ff, s5_valid_ff;
   logic rdy4, rdy5;

   assign rdy5 = !s5_valid_ff || out_ready;
   assign rdy4 = !s4_valid_ff || rdy5;
   assign in_ready = rdy4;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (rdy4) s4_valid_ff <= in_valid;
         if (rdy5) s5_valid_ff <= s4_valid_ff;
      end
   end

   // ---------------- stage 4: six squares
   spot_pkg::op_type s4_op_ff;
   logic [QW-1:0]    s4_sq_x_ff, s4_sq_x_in;
   logic [QW-1:0]    s4_sq_y_ff, s4_sq_y_in;
   logic [QW-1:0]    s4_sq_lim_ff, s4_sq_lim_in;
   logic [QW-1:0]    s4_sq_cx_ff, s4_sq_cx_in;
   logic [QW-1:0]    s4_sq_cy_ff, s4_sq_cy_in;
   logic [QW-1:0]    s4_sq_r2_ff, s4_sq_r2_in;
   logic             s4_rr_ff, s4_ctr_ff, s4_side_ff;

   always_comb begin
      logic [OW-1:0] ox, oy, ol, ocx, ocy, or2;
      ox  = OW'(in_geom.mag_x);
      oy  = OW'(in_geom.mag_y);
      ol  = OW'(in_geom.lim);
      ocx = in_geom.cmag_x;
      ocy = in_geom.cmag_y;
      or2 = OW'(in_geom.r2);
      s4_sq_x_in   = ox * ox;
      s4_sq_y_in   = oy * oy;
      s4_sq_lim_in = ol * ol;
      s4_sq_cx_in  = ocx * ocx;
      s4_sq_cy_in  = ocy * ocy;
      s4_sq_r2_in  = or2 * or2;
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_op_ff     <= in_geom.op;
         s4_sq_x_ff   <= s4_sq_x_in;
         s4_sq_y_ff   <= s4_sq_y_in;
         s4_sq_lim_ff <= s4_sq_lim_in;
         s4_sq_cx_ff  <= s4_sq_cx_in;
         s4_sq_cy_ff  <= s4_sq_cy_in;
         s4_sq_r2_ff  <= s4_sq_r2_in;
         s4_rr_ff     <= in_geom.rr;
         s4_ctr_ff    <= in_geom.ctr;
         s4_side_ff   <= in_geom.side;
      end
   end

   // ---------------- stage 5: distance compares and final answer
   logic s5_hit_ff, s5_hit_in;

   always_comb begin
      logic [SQW-1:0] near_sum, corner_sum;
      logic           near, corner;
      near_sum   = SQW'(s4_sq_x_ff) + SQW'(s4_sq_y_ff);
      corner_sum = SQW'(s4_sq_cx_ff) + SQW'(s4_sq_cy_ff);
      near       = near_sum < SQW'(s4_sq_lim_ff);
      corner     = corner_sum < SQW'(s4_sq_r2_ff);
      case (s4_op_ff)
         spot_pkg::OP_RR: begin
            s5_hit_in = s4_rr_ff;
         end
         spot_pkg::OP_RC: begin
            // coarse reject gates the three accept tests
            s5_hit_in = near && (s4_ctr_ff || corner || s4_side_ff);
         end
         spot_pkg::OP_CC: begin
            s5_hit_in = near;
         end
         default: begin
            s5_hit_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy5) s5_hit_ff <= s5_hit_in;
   end

   assign out_valid = s5_valid_ff;
   assign out_hit   = s5_hit_ff;

   // the output stage comes out of reset empty
   `SPOT_ASSERT_NR(a_dist_reset_empty, clock, $past(reset) |-> !s5_valid_ff)
   // the unused pair kind never reports a hit
   `SPOT_ASSERT(a_dist_none_misses, clock, reset, s4_valid_ff && rdy5 && s4_op_ff == spot_pkg::OP_NONE |=> !s5_hit_ff)
   // a squared-distance word waits while the output is blocked
   `SPOT_ASSERT(a_dist_stall_keeps, clock, reset, s4_valid_ff && !rdy5 |=> s4_valid_ff)

endmodule

`default_nettype wire

// File: rtl/shape_pair_overlap_tester.sv
// Shape pair overlap tester: one hit bit per shape pair word.
// Pipeline: 5 register stages (s1 to s5) between the req accepting edge and rsp_tvalid.
// Throughput: one pair per cycle while rsp_tready is high; the 26x26 squaring stage sets the cycle depth.
// Backpressure stalls the pipeline stage by stage; bubbles are filled while rsp waits.
// Reset (synchronous, active high) empties every stage; no other state is held.
`timescale 1ns / 1ps
`default_nettype none

module shape_pair_overlap_tester (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h, zero pad
   input  logic [spot_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // op
   input  logic [spot_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // hit, zero pad
   output logic [spot_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int CW = spot_pkg::CW;
   localparam int SW = spot_pkg::SW;

   spot_pkg::pair_type pair;
   spot_pkg::geom_type geom;
   logic               geom_valid, geom_ready;
   logic               hit;

   // unpack the request word
   assign pair.op  = spot_pkg::op_type'(req_tuser);
   assign pair.a_x = req_tdata[0 +: CW];
   assign pair.a_y = req_tdata[CW +: CW];
   assign pair.a_w = req_tdata[2*CW +: SW];
   assign pair.a_h = req_tdata[2*CW + SW +: SW];
   assign pair.b_x = req_tdata[2*CW + 2*SW +: CW];
   assign pair.b_y = req_tdata[3*CW + 2*SW +: CW];
   assign pair.b_w = req_tdata[4*CW + 2*SW +: SW];
   assign pair.b_h = req_tdata[4*CW + 3*SW +: SW];

   spot_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pair   (pair),
      .out_valid (geom_valid),
      .out_ready (geom_ready),
      .out_geom  (geom)
   );

   spot_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (geom_valid),
      .in_ready  (geom_ready),
      .in_geom   (geom),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hit   (hit)
   );

   // pack the response word
   assign rsp_tdata = {{(spot_pkg::RSP_TDATA_W-1){1'b0}}, hit};

endmodule

`default_nettype wire

// File: sim/shape_pair_overlap_checker.sv
`timescale 1ns / 1ps

// Watches both stream channels of the overlap tester, predicts the hit bit of
// every accepted pair word and compares it with the returned result words.
module shape_pair_overlap_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   // a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h, zero pad
   input  logic [spot_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // op
   input  logic [spot_pkg::REQ_TUSER_W-1:0]   req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // hit, zero pad
   input  logic [spot_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output int                                 fail_count,
   output int                                 pending_count
);

   localparam int CW = spot_pkg::CW;
   localparam int SW = spot_pkg::SW;

   // field offsets inside req_tdata
   localparam int AX_LSB = 0;
   localparam int AY_LSB = CW;
   localparam int AW_LSB = 2 * CW;
   localparam int AH_LSB = 2 * CW + SW;
   localparam int BX_LSB = 2 * CW + 2 * SW;
   localparam int BY_LSB = 3 * CW + 2 * SW;
   localparam int BW_LSB = 4 * CW + 2 * SW;
   localparam int BH_LSB = 4 * CW + 3 * SW;

   typedef struct {
      spot_pkg::pair_type pair;
      bit                 hit;
   } hit_entry_type;

   hit_entry_type hit_queue[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic longint mag(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // exact dx^2 + dy^2 < lim^2; every operand stays far below 2^31
   function automatic bit below_sumsq(longint dx, longint dy, longint lim);
      return dx * dx + dy * dy < lim * lim;
   endfunction

   // rect centered at (rx, ry) against circle at (cx, cy) with radius r
   function automatic bit rect_circle_hit(longint rx, longint ry, longint w, longint h,
                                          longint cx, longint cy, longint r);
      longint big, px2, py2, ex, ey;
      big = (w < h) ? h : w;
      // coarse reject on full larger side plus radius
      if (!below_sumsq(rx - cx, ry - cy, big + r))
         return 1'b0;
      // circle center inside the rect
      if (2 * mag(rx - cx) < w && 2 * mag(ry - cy) < h)
         return 1'b1;
      // nearest corner, all in doubled coordinates
      px2 = (cx < rx) ? 2 * rx - w : 2 * rx + w;
      py2 = (cy < ry) ? 2 * ry - h : 2 * ry + h;
      if (below_sumsq(px2 - 2 * cx, py2 - 2 * cy, 2 * r))
         return 1'b1;
      // left/right edges
      if (2 * cy < 2 * ry + h && 2 * cy > 2 * ry - h) begin
         ex = (cx < rx) ? cx + r : cx - r;
         if (2 * mag(ex - rx) < w)
            return 1'b1;
      end
      // top/bottom edges
      if (2 * cx < 2 * rx + w && 2 * cx > 2 * rx - w) begin
         ey = (cy < ry) ? cy + r : cy - r;
         if (2 * mag(ey - ry) < h)
            return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit overlap_hit(spot_pkg::pair_type p);
      longint ax, ay, aw, ah, bx, by, bw, bh;
      ax = $signed(p.a_x);
      ay = $signed(p.a_y);
      bx = $signed(p.b_x);
      by = $signed(p.b_y);
      aw = p.a_w;
      ah = p.a_h;
      bw = p.b_w;
      bh = p.b_h;
      case (p.op)
         spot_pkg::OP_RR: return 2 * mag(ax - bx) < aw + bw && 2 * mag(ay - by) < ah + bh;
         spot_pkg::OP_RC: return rect_circle_hit(ax, ay, aw, ah, bx, by, bw);
         spot_pkg::OP_CC: return below_sumsq(ax - bx, ay - by, aw + bw);
         default: return 1'b0;
      endcase
   endfunction

   // predict on every accepted pair word, compare on every accepted result word
   always @(posedge clock) begin : watch
      spot_pkg::pair_type seen;
      hit_entry_type      exp_entry;
      if (!reset && req_tvalid && req_tready) begin
         seen.op  = spot_pkg::op_type'(req_tuser);
         seen.a_x = req_tdata[AX_LSB +: CW];
         seen.a_y = req_tdata[AY_LSB +: CW];
         seen.a_w = req_tdata[AW_LSB +: SW];
         seen.a_h = req_tdata[AH_LSB +: SW];
         seen.b_x = req_tdata[BX_LSB +: CW];
         seen.b_y = req_tdata[BY_LSB +: CW];
         seen.b_w = req_tdata[BW_LSB +: SW];
         seen.b_h = req_tdata[BH_LSB +: SW];
         exp_entry.pair = seen;
         exp_entry.hit  = overlap_hit(seen);
         hit_queue.push_back(exp_entry);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hit_queue.size() == 0) begin
            $display("%0t: result word with nothing expected: expected none, actual hit %0d",
                     $time, rsp_tdata[0]);
            fail_count = fail_count + 1;
         end else begin
            exp_entry = hit_queue.pop_front();
            if (rsp_tdata[0] !== exp_entry.hit) begin
               $display("%0t: hit mismatch (op %s): expected %0d, actual %0d",
                        $time, exp_entry.pair.op.name(), exp_entry.hit, rsp_tdata[0]);
               fail_count = fail_count + 1;
            end
         end
      end
      pending_count = hit_queue.size();
   end

endmodule

// File: sim/shape_pair_overlap_tester_tb.sv
`timescale 1ns / 1ps

module shape_pair_overlap_tester_tb;

   localparam int CW                = spot_pkg::CW;
   localparam int SW                = spot_pkg::SW;
   localparam int REQ_TDATA_W       = spot_pkg::REQ_TDATA_W;
   localparam int RANDOM_PER_PHASE  = 433;
   localparam int LONG_STALL_CYCLES = 300;
   localparam int DRAIN_CYCLES      = 20;

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   // a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h, zero pad
   logic [spot_pkg::REQ_TDATA_W-1:0]    req_tdata;
   // op
   logic [spot_pkg::REQ_TUSER_W-1:0]    req_tuser;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   // hit, zero pad
   logic [spot_pkg::RSP_TDATA_W-1:0]    rsp_tdata;

   int fail_count;
   int pending_count;
   int send_idle_pct;
   int recv_idle_pct;
   bit long_stall;

   shape_pair_overlap_tester dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   shape_pair_overlap_checker overlap_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 4 ns clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // overall time limit
   initial begin
      #2_000_000;
      $display("shape_pair_overlap_tester test failed");
      $finish;
   end

   function automatic spot_pkg::pair_type make_pair(spot_pkg::op_type op,
                                                    int ax, int ay, int aw, int ah,
                                                    int bx, int by, int bw, int bh);
      spot_pkg::pair_type p;
      p.op  = op;
      p.a_x = CW'(ax);
      p.a_y = CW'(ay);
      p.a_w = SW'(aw);
      p.a_h = SW'(ah);
      p.b_x = CW'(bx);
      p.b_y = CW'(by);
      p.b_w = SW'(bw);
      p.b_h = SW'(bh);
      return p;
   endfunction

   // mostly nearby shapes of related size, some pairs fully random
   function automatic spot_pkg::pair_type random_pair();
      spot_pkg::pair_type p;
      int unsigned        scale;
      if ($urandom_range(99) < 8)
         p.op = spot_pkg::OP_NONE;
      else
         p.op = spot_pkg::op_type'($urandom_range(2));
      if ($urandom_range(3) == 0) begin
         p.a_x = CW'($urandom);
         p.a_y = CW'($urandom);
         p.a_w = SW'($urandom);
         p.a_h = SW'($urandom);
         p.b_x = CW'($urandom);
         p.b_y = CW'($urandom);
         p.b_w = SW'($urandom);
         p.b_h = SW'($urandom);
      end else begin
         scale = 1 << $urandom_range(16, 4);
         p.a_x = CW'(int'($urandom_range(1 << 23)) - (1 << 22));
         p.a_y = CW'(int'($urandom_range(1 << 23)) - (1 << 22));
         p.b_x = CW'(p.a_x + int'($urandom_range(4 * scale)) - int'(2 * scale));
         p.b_y = CW'(p.a_y + int'($urandom_range(4 * scale)) - int'(2 * scale));
         p.a_w = SW'($urandom_range(2 * scale));
         p.a_h = SW'($urandom_range(2 * scale));
         p.b_w = SW'($urandom_range(2 * scale));
         p.b_h = SW'($urandom_range(2 * scale));
         if ($urandom_range(15) == 0)
            p.a_w = '0;
         if ($urandom_range(15) == 0)
            p.b_w = '0;
      end
      return p;
   endfunction

   // offer one pair word; entered and left at a falling edge
   task automatic send_pair(input spot_pkg::pair_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= p.op;
      req_tdata  <= REQ_TDATA_W'({p.b_h, p.b_w, p.b_y, p.b_x, p.a_h, p.a_w, p.a_y, p.a_x});
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // result side ready, with an optional long hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_stall) begin
            rsp_tready <= 1'b0;
            repeat (LONG_STALL_CYCLES) @(negedge clock);
            long_stall = 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // stimulus and verdict
   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      send_idle_pct = 7;
      recv_idle_pct = 87;
      long_stall    = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // rect-rect: overlap, touching edges, zero sizes, extremes
      send_pair(make_pair(spot_pkg::OP_RR, 0, 0, 512, 512, 256, 0, 512, 512));
      send_pair(make_pair(spot_pkg::OP_RR, 0, 0, 512, 512, 512, 0, 512, 512));
      send_pair(make_pair(spot_pkg::OP_RR, 100, 100, 0, 0, 100, 100, 0, 0));
      send_pair(make_pair(spot_pkg::OP_RR, -8388608, -8388608, 8388607, 8388607,
                          8388607, 8388607, 8388607, 8388607));
      send_pair(make_pair(spot_pkg::OP_RR, 8388607, 8388607, 8388607, 8388607,
                          8388607, 8388607, 8388607, 8388607));
      // circle-circle: overlap, touching, zero radii, extremes
      send_pair(make_pair(spot_pkg::OP_CC, 0, 0, 256, 0, 300, -200, 256, 0));
      send_pair(make_pair(spot_pkg::OP_CC, 0, 0, 256, 0, 512, 0, 256, 0));
      send_pair(make_pair(spot_pkg::OP_CC, -50, 70, 0, 0, -50, 70, 0, 0));
      send_pair(make_pair(spot_pkg::OP_CC, -8388608, -8388608, 8388607, 8388607,
                          8388607, 8388607, 8388607, 8388607));
      send_pair(make_pair(spot_pkg::OP_CC, 8388607, -8388608, 8388607, 0,
                          8388607, -8388608, 8388607, 0));
      // rect-circle: coarse reject, center inside, corner, side edge
      send_pair(make_pair(spot_pkg::OP_RC, 0, 0, 512, 512, 10000, 10000, 256, 0));
      send_pair(make_pair(spot_pkg::OP_RC, 0, 0, 1024, 512, 100, 50, 10, 0));
      send_pair(make_pair(spot_pkg::OP_RC, 0, 0, 512, 512, 400, 400, 210, 0));
      send_pair(make_pair(spot_pkg::OP_RC, 0, 0, 512, 512, 400, 400, 200, 0));
      send_pair(make_pair(spot_pkg::OP_RC, 0, 0, 512, 512, 400, 0, 200, 0));
      send_pair(make_pair(spot_pkg::OP_RC, 0, 0, 512, 512, 0, -400, 200, 0));
      // rect-circle: zero-size rect, zero radius, extremes
      send_pair(make_pair(spot_pkg::OP_RC, 64, 64, 0, 0, 64, 64, 32, 0));
      send_pair(make_pair(spot_pkg::OP_RC, 64, 64, 0, 0, 64, 64, 0, 0));
      send_pair(make_pair(spot_pkg::OP_RC, -8388608, 8388607, 8388607, 8388607,
                          8388607, -8388608, 8388607, 8388607));
      send_pair(make_pair(spot_pkg::OP_RC, 8388607, 8388607, 8388607, 8388607,
                          -8388608, -8388608, 8388607, 8388607));
      // unused op on overlapping shapes never hits
      send_pair(make_pair(spot_pkg::OP_NONE, 0, 0, 512, 512, 0, 0, 512, 512));
      send_pair(make_pair(spot_pkg::OP_NONE, -1, -1, 8388607, 8388607,
                          -1, -1, 8388607, 8388607));

      // random, slow receiver
      repeat (RANDOM_PER_PHASE) send_pair(random_pair());

      // random, slow sender
      send_idle_pct = 87;
      recv_idle_pct = 7;
      repeat (RANDOM_PER_PHASE) send_pair(random_pair());

      // random, no idling, with one long receiver hold-off up front
      send_idle_pct = 0;
      recv_idle_pct = 0;
      long_stall    = 1'b1;
      repeat (RANDOM_PER_PHASE) send_pair(random_pair());

      req_tvalid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("shape_pair_overlap_tester test passed");
      else
         $display("shape_pair_overlap_tester test failed");
      $finish;
   end

endmodule
